// ===== rtl/core/brm_pkg.sv =====
// ----------------------------------------------------------------------------
// brm_pkg
// Types and constants shared by the baud rate meter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package brm_pkg;

	// Field widths
	localparam int CLOCK_W   = 28;
	localparam int STAMP_W   = 32;
	localparam int BAUD_W    = 29;
	localparam int ELAPSED_W = 12;

	// Command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_EDGE  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// Clock frequency after reset
	localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(72000000);

	// Timeout limits in milliseconds and the edge counts they check
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
	localparam logic [ELAPSED_W-1:0] TMO_SHORT_MS = ELAPSED_W'(1500);
	localparam logic [ELAPSED_W-1:0] TMO_MID_MS   = ELAPSED_W'(2000);
	localparam logic [ELAPSED_W-1:0] TMO_LONG_MS  = ELAPSED_W'(4000);
	localparam logic [15:0] TMO_SHORT_EDGES = 16'd10;
	localparam logic [15:0] TMO_MID_EDGES   = 16'd50;

	// Standard rates and their tolerances (a tenth of the rate, truncated)
	localparam int STD_COUNT = 11;
	localparam int STD_W     = 18;
	localparam logic [STD_W-1:0] STD_RATE [STD_COUNT] = '{
		18'd1200, 18'd2400, 18'd4800, 18'd9600, 18'd14400, 18'd19200,
		18'd28800, 18'd38400, 18'd57600, 18'd115200, 18'd230400
	};
	localparam logic [STD_W-1:0] STD_TOL [STD_COUNT] = '{
		18'd120, 18'd240, 18'd480, 18'd960, 18'd1440, 18'd1920,
		18'd2880, 18'd3840, 18'd5760, 18'd11520, 18'd23040
	};

	// Channel payloads
	typedef struct packed {
		logic [1:0]         command;
		logic [STAMP_W-1:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic [BAUD_W-1:0] raw_baud;
		logic [BAUD_W-1:0] rounded_baud;
		logic              failed;
	} out_item_t;

	// Window outcome for the transfer being accepted
	typedef struct packed {
		logic               fail;
		logic               finish;
		logic [STAMP_W-1:0] divisor;
	} win_evt_t;

	// Divider request and status
	typedef struct packed {
		logic               start;
		logic [BAUD_W-1:0]  dividend;
		logic [STAMP_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [BAUD_W-1:0] quotient;
	} div_rsp_t;

	// Last standard rate strictly within its tolerance, else the raw rate
	function automatic logic [BAUD_W-1:0] round_rate(input logic [BAUD_W-1:0] raw);
		logic [BAUD_W-1:0] best;
		logic [BAUD_W-1:0] lo;
		logic [BAUD_W-1:0] hi;
		best = raw;
		for (int i = 0; i < STD_COUNT; i++) begin
			lo = BAUD_W'(STD_RATE[i] - STD_TOL[i]);
			hi = BAUD_W'(STD_RATE[i] + STD_TOL[i]);
			if (raw > lo && raw < hi) begin
				best = BAUD_W'(STD_RATE[i]);
			end
		end
		return best;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/baud_rate_meter_top.sv =====
// ----------------------------------------------------------------------------
// baud_rate_meter_top
// Serial line baud rate meter with standard rate rounding.
// ----------------------------------------------------------------------------
// Start, tick and ordinary edge transfers are taken while idle with the
// output free. The edge that completes the window starts a bit-serial
// divider (twice the clock register over the shortest interval) that
// produces one quotient bit per cycle, then a done strobe and a state that
// rounds and loads the output register; no input is taken meanwhile. Timeouts
// and zero intervals report a failure in the cycle after the transfer. The
// output register lets a new input be taken while its result is consumed.
`default_nettype none

module baud_rate_meter_top import brm_pkg::*; #(
	parameter int EDGE_BUFFER_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire in_item_t           in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output out_item_t               out_item,
	input  wire logic               cfg_we,
	input  wire logic [CLOCK_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_DIV   = 3'b010,
		S_ROUND = 3'b100
	} state_t;

	state_t             state_q;
	logic [CLOCK_W-1:0] clock_q;
	logic               out_valid_q;
	out_item_t          out_item_q;

	logic      accept;
	logic      out_free;
	win_evt_t  evt;
	div_req_t  div_req;
	div_rsp_t  div_rsp;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	// Clock frequency register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= CLOCK_RESET;
		end else if (cfg_we) begin
			clock_q <= cfg_wdata;
		end
	end

	brm_window #(
		.EDGE_BUFFER_DEPTH(EDGE_BUFFER_DEPTH)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_item),
		.evt    (evt)
	);

	assign div_req.start    = evt.finish;
	assign div_req.dividend = {clock_q, 1'b0};
	assign div_req.divisor  = evt.divisor;

	brm_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (evt.finish) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (evt.fail || (state_q == S_ROUND && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.fail) begin
			out_item_q.raw_baud     <= '0;
			out_item_q.rounded_baud <= '0;
			out_item_q.failed       <= 1'b1;
		end else if (state_q == S_ROUND && out_free) begin
			out_item_q.raw_baud     <= div_rsp.quotient;
			out_item_q.rounded_baud <= round_rate(div_rsp.quotient);
			out_item_q.failed       <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

// ===== rtl/core/brm_window.sv =====
// ----------------------------------------------------------------------------
// brm_window
// Measurement window: edge count, shortest interval, millisecond timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_window import brm_pkg::*; #(
	parameter int EDGE_BUFFER_DEPTH = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire in_item_t item,
	output win_evt_t      evt
);

	localparam int CNT_W = $clog2(EDGE_BUFFER_DEPTH + 1);

	logic                 measuring_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [CNT_W-1:0]     edge_cnt_q;
	logic [STAMP_W-1:0]   prev_q;
	logic [STAMP_W-1:0]   short_q;

	logic [STAMP_W-1:0]   interval;
	logic [STAMP_W-1:0]   short_nx;
	logic [CNT_W-1:0]     cnt_nx;
	logic [ELAPSED_W-1:0] elapsed_nx;
	logic [15:0]          cnt_x;
	logic                 full;
	logic                 timeout;

	// Edge path: interval modulo 2^32 and running minimum
	assign interval = item.timestamp - prev_q;
	assign short_nx = (edge_cnt_q != '0 && interval < short_q) ? interval : short_q;
	assign cnt_nx   = edge_cnt_q + 1'b1;
	assign full     = cnt_nx >= CNT_W'(EDGE_BUFFER_DEPTH);

	// Tick path: saturating elapsed time and the three timeouts
	assign elapsed_nx = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign cnt_x      = 16'(edge_cnt_q);
	assign timeout    = (elapsed_nx > TMO_SHORT_MS && cnt_x < TMO_SHORT_EDGES) ||
	                    (elapsed_nx > TMO_MID_MS && cnt_x < TMO_MID_EDGES) ||
	                    (elapsed_nx > TMO_LONG_MS);

	// Outcome of the accepted transfer
	always_comb begin
		evt.fail    = 1'b0;
		evt.finish  = 1'b0;
		evt.divisor = short_nx;
		if (accept && measuring_q) begin
			if (item.command == CMD_EDGE && full) begin
				evt.fail   = (short_nx == '0);
				evt.finish = (short_nx != '0);
			end else if (item.command == CMD_TICK && timeout) begin
				evt.fail = 1'b1;
			end
		end
	end

	// Window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measuring_q <= 1'b0;
			elapsed_q   <= '0;
			edge_cnt_q  <= '0;
			prev_q      <= '0;
			short_q     <= '1;
		end else if (accept) begin
			if (item.command == CMD_START) begin
				measuring_q <= 1'b1;
				elapsed_q   <= '0;
				edge_cnt_q  <= '0;
				prev_q      <= '0;
				short_q     <= '1;
			end else if (measuring_q && item.command == CMD_EDGE) begin
				short_q    <= short_nx;
				prev_q     <= item.timestamp;
				edge_cnt_q <= cnt_nx;
				if (full) begin
					measuring_q <= 1'b0;
				end
			end else if (measuring_q && item.command == CMD_TICK) begin
				elapsed_q <= elapsed_nx;
				if (timeout) begin
					measuring_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/brm_divider.sv =====
// ----------------------------------------------------------------------------
// brm_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_divider import brm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int CNT_W = $clog2(BAUD_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [STAMP_W-1:0] rem_q;
	logic [BAUD_W-1:0]  dvd_q;
	logic [STAMP_W-1:0] dvs_q;

	logic [STAMP_W:0]   trial;
	logic [STAMP_W:0]   diff;
	logic               fits;

	// One trial subtraction per cycle
	assign trial = {rem_q, dvd_q[BAUD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = !diff[STAMP_W];

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(BAUD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out the top, quotient bits shift in below
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[STAMP_W-1:0] : trial[STAMP_W-1:0];
			dvd_q <= {dvd_q[BAUD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

`default_nettype wire

// ===== test/baud_rate_meter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baud_rate_meter_checker
// Watches both channels and the clock register port of the baud rate meter,
// keeps its own model of the measurement window, and compares every result
// transfer field by field with the oldest predicted rate.
// ----------------------------------------------------------------------------

module baud_rate_meter_checker import brm_pkg::*; #(
	parameter int EDGE_BUFFER_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire in_item_t           in_item,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire out_item_t          out_item,
	input  wire logic               cfg_we,
	input  wire logic [CLOCK_W-1:0] cfg_wdata,
	output int                      mismatches,
	output int                      awaited,
	output int                      results,
	output int                      failed_windows
);

	// Model state
	logic [CLOCK_W-1:0]   clock_hz_q  = CLOCK_RESET;
	logic                 window_open = 1'b0;
	logic [ELAPSED_W-1:0] ms_count    = '0;
	int unsigned          edges_seen  = 0;
	logic [STAMP_W-1:0]   last_stamp  = '0;
	logic [STAMP_W-1:0]   min_gap     = '1;
	out_item_t            rate_queue [$];
	int                   bad_count   = 0;
	int                   got_count   = 0;
	int                   fail_count  = 0;

	// Snap to the last standard rate whose distance is under a tenth of it
	function automatic logic [BAUD_W-1:0] snap_to_standard(input logic [BAUD_W-1:0] raw);
		logic [BAUD_W-1:0] pick;
		int unsigned       rate;
		int unsigned       margin;
		int unsigned       offset;
		pick = raw;
		for (int i = 0; i < STD_COUNT; i++) begin
			rate   = STD_RATE[i];
			margin = rate / 10;
			offset = (rate > raw) ? rate - raw : raw - rate;
			if (raw != '0 && offset < margin) begin
				pick = BAUD_W'(rate);
			end
		end
		return pick;
	endfunction

	// Window ends: queue the result and go idle
	function automatic void close_window(input logic [BAUD_W-1:0] raw,
			input logic [BAUD_W-1:0] rounded, input logic failed);
		out_item_t res;
		res.raw_baud     = raw;
		res.rounded_baud = rounded;
		res.failed       = failed;
		rate_queue.push_back(res);
		window_open = 1'b0;
	endfunction

	// Advance the model by one input transfer
	function automatic void predict_measurement(input in_item_t it);
		logic [STAMP_W-1:0] gap;
		logic [63:0]        quotient;
		case (it.command)
			CMD_START: begin
				window_open = 1'b1;
				ms_count    = '0;
				edges_seen  = 0;
				last_stamp  = '0;
				min_gap     = '1;
			end
			CMD_EDGE: begin
				if (window_open) begin
					if (edges_seen > 0) begin
						gap = it.timestamp - last_stamp;
						if (gap < min_gap) begin
							min_gap = gap;
						end
					end
					last_stamp = it.timestamp;
					edges_seen++;
					if (edges_seen >= EDGE_BUFFER_DEPTH) begin
						if (min_gap == '0) begin
							close_window('0, '0, 1'b1);
						end else begin
							quotient = ({36'd0, clock_hz_q} << 1) / {32'd0, min_gap};
							close_window(quotient[BAUD_W-1:0],
								snap_to_standard(quotient[BAUD_W-1:0]), 1'b0);
						end
					end
				end
			end
			CMD_TICK: begin
				if (window_open) begin
					if (ms_count != ELAPSED_MAX) begin
						ms_count++;
					end
					if ((ms_count > TMO_SHORT_MS && edges_seen < TMO_SHORT_EDGES) ||
							(ms_count > TMO_MID_MS && edges_seen < TMO_MID_EDGES) ||
							ms_count > TMO_LONG_MS) begin
						close_window('0, '0, 1'b1);
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Sample at the clock edge: register writes, results, then inputs
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			clock_hz_q  = CLOCK_RESET;
			window_open = 1'b0;
			ms_count    = '0;
			edges_seen  = 0;
			last_stamp  = '0;
			min_gap     = '1;
			rate_queue.delete();
		end else begin
			if (cfg_we) begin
				clock_hz_q = cfg_wdata;
			end
			// result transfer against the oldest prediction
			if (out_valid && out_ready) begin
				got_count++;
				if (out_item.failed === 1'b1) begin
					fail_count++;
				end
				if (rate_queue.size() == 0) begin
					if (bad_count < 10) begin
						$display("%0t: unexpected result raw %0d rounded %0d failed %0b",
							$realtime, out_item.raw_baud, out_item.rounded_baud,
							out_item.failed);
					end
					bad_count++;
				end else begin
					want = rate_queue.pop_front();
					if (out_item.raw_baud !== want.raw_baud ||
							out_item.rounded_baud !== want.rounded_baud ||
							out_item.failed !== want.failed) begin
						if (bad_count < 10) begin
							$display("%0t: result %0d expected raw %0d rounded %0d failed %0b",
								$realtime, got_count, want.raw_baud, want.rounded_baud,
								want.failed);
							$display("%0t: result %0d got      raw %0d rounded %0d failed %0b",
								$realtime, got_count, out_item.raw_baud,
								out_item.rounded_baud, out_item.failed);
						end
						bad_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_measurement(in_item);
			end
		end
		mismatches     <= bad_count;
		awaited        <= rate_queue.size();
		results        <= got_count;
		failed_windows <= fail_count;
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the baud rate meter with measurement windows built from standard
// rates, tolerance borders, zero and wrapping intervals and abandoned
// windows, over several clock register settings and handshake stall
// patterns. The checker module predicts and compares.
// ----------------------------------------------------------------------------

module testbench;
	import brm_pkg::*;

	localparam int          CLK_PERIOD    = 10;
	localparam int          METER_DEPTH   = 64;
	localparam int          QUIET_LIMIT   = 5000;
	localparam int          SETTLE_CYCLES = 40;
	localparam int          HOLD_CYCLES   = 800;
	localparam int          PHASE_ITEMS   = 250;
	localparam logic [1:0]  CMD_UNUSED    = 2'd3;
	localparam int unsigned PHASE_CLOCKS [6] = '{
		200000000, 1, 32'h0FFF_FFFF, 0, 0, 72000000
	};

	typedef enum int {
		WIN_TYPICAL,
		WIN_BORDER,
		WIN_ZERO_GAP,
		WIN_WILD,
		WIN_ABANDON,
		WIN_STRAY
	} window_kind_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	in_item_t           in_item   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_item_t          out_item;
	logic               cfg_we    = 1'b0;
	logic [CLOCK_W-1:0] cfg_wdata = '0;

	int                 mismatches;
	int                 awaited;
	int                 results;
	int                 failed_windows;

	int                 tx_idle_pct  = 19;
	int                 rx_idle_pct  = 54;
	logic               hold_req     = 1'b0;
	logic               hold_ack     = 1'b0;
	int                 hold_left    = 0;
	int                 quiet_cycles = 0;
	int                 items_sent   = 0;
	int unsigned        clock_now    = CLOCK_RESET;
	logic [STAMP_W-1:0] stamp_cursor = '0;
	logic               meter_open   = 1'b0;

	baud_rate_meter_top #(
		.EDGE_BUFFER_DEPTH(METER_DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	baud_rate_meter_checker #(
		.EDGE_BUFFER_DEPTH(METER_DEPTH)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_item       (out_item),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mismatches     (mismatches),
		.awaited        (awaited),
		.results        (results),
		.failed_windows (failed_windows)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Result side: random stalls, or a long hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_ack  <= 1'b0;
			hold_left <= 0;
		end else if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
			$display("baud_rate_meter_top: mismatch");
			$finish;
		end
	end

	// One input transfer, then a random sender gap
	task automatic push(input logic [1:0] cmd, input logic [STAMP_W-1:0] stamp,
			input bit live);
		in_item_t word;
		int       gap;
		word.command   = cmd;
		word.timestamp = stamp;
		in_valid <= 1'b1;
		in_item  <= word;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (live) begin
			items_sent++;
		end
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted result has been taken
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_clock(input int unsigned hz);
		drain_results();
		clock_now = hz & 32'h0FFF_FFFF;
		cfg_we    <= 1'b1;
		cfg_wdata <= CLOCK_W'(hz);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idle(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
	endtask

	// Full window with one fixed interval between all edges
	task automatic even_window(input logic [STAMP_W-1:0] first,
			input logic [STAMP_W-1:0] step);
		push(CMD_START, $urandom(), 1'b1);
		stamp_cursor = first;
		for (int e = 0; e < METER_DEPTH; e++) begin
			push(CMD_EDGE, stamp_cursor, 1'b1);
			stamp_cursor += step;
		end
		meter_open = 1'b0;
	endtask

	// One measurement window shaped by kind, with ticks and unused codes mixed in
	task automatic measure_window(input window_kind_t kind);
		int unsigned rate;
		int unsigned margin;
		int unsigned target;
		int unsigned bit_len;
		int unsigned step;
		int unsigned n_edges;
		int unsigned zero_at;
		int unsigned pick;
		logic [1:0]  cmd;
		if (kind == WIN_STRAY) begin
			repeat ($urandom_range(1, 4)) begin
				case ($urandom_range(2))
					0:       cmd = CMD_EDGE;
					1:       cmd = CMD_TICK;
					default: cmd = CMD_UNUSED;
				endcase
				push(cmd, $urandom(), meter_open && cmd != CMD_UNUSED);
			end
			return;
		end
		rate   = STD_RATE[$urandom_range(STD_COUNT - 1)];
		margin = rate / 10;
		case (kind)
			WIN_TYPICAL: begin
				target = rate * $urandom_range(850, 1150) / 1000;
			end
			WIN_BORDER: begin
				// just inside, on and just outside both tolerance borders
				pick   = $urandom_range(5);
				target = (pick < 3) ? rate - margin - 1 + pick : rate + margin - 4 + pick;
			end
			default: begin
				target = rate;
			end
		endcase
		bit_len = (clock_now * 2) / target;
		if (bit_len == 0) begin
			bit_len = 1;
		end
		n_edges = (kind == WIN_ABANDON) ? $urandom_range(1, METER_DEPTH - 1) : METER_DEPTH;
		zero_at = $urandom_range(1, METER_DEPTH - 1);
		// a quarter of the windows start close to the counter wrap
		stamp_cursor = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(65535)
			: $urandom();
		push(CMD_START, $urandom(), 1'b1);
		meter_open = 1'b1;
		for (int e = 0; e < n_edges; e++) begin
			if (e == 0) begin
				step = 0;
			end else if (kind == WIN_ZERO_GAP && e == zero_at) begin
				step = 0;
			end else if (kind == WIN_WILD) begin
				step = $urandom() >> $urandom_range(31);
			end else if (e == 1) begin
				step = bit_len;
			end else begin
				step = bit_len * $urandom_range(1, 10) + $urandom_range(bit_len / 16);
			end
			stamp_cursor += step;
			push(CMD_EDGE, stamp_cursor, 1'b1);
			if (e < n_edges - 1 || kind == WIN_ABANDON) begin
				if ($urandom_range(99) < 8) begin
					push(CMD_TICK, $urandom(), 1'b1);
				end
				if ($urandom_range(99) < 3) begin
					push(CMD_UNUSED, $urandom(), 1'b0);
				end
			end
		end
		if (kind != WIN_ABANDON) begin
			meter_open = 1'b0;
		end
	endtask

	initial begin
		int           phase_items;
		int unsigned  roll;
		window_kind_t kind;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: transfers while idle are dropped, restart, unused code
		push(CMD_EDGE, '1, 1'b0);
		push(CMD_TICK, '0, 1'b0);
		push(CMD_UNUSED, '1, 1'b0);
		push(CMD_EDGE, '0, 1'b0);
		push(CMD_START, '1, 1'b1);
		push(CMD_TICK, '1, 1'b1);
		push(CMD_EDGE, '0, 1'b1);
		push(CMD_UNUSED, '0, 1'b1);
		push(CMD_START, '0, 1'b1);
		push(CMD_EDGE, '1, 1'b1);
		// largest interval, smallest interval, zero interval
		even_window('0, '1);
		even_window(32'hFFFF_FFF0, 32'd1);
		even_window(32'h1234_5678, '0);

		// Random windows in six phases, each with a clock setting, and three stall patterns
		for (int p = 0; p < 6; p++) begin
			load_clock((p == 4) ? $urandom_range(1, 200000000) : PHASE_CLOCKS[p]);
			case (p / 2)
				0:       set_idle(19, 54);
				1:       set_idle(54, 19);
				default: set_idle(0, 0);
			endcase
			if (p == 1) begin
				hold_req <= ~hold_req;
			end
			phase_items = items_sent;
			while (items_sent - phase_items < PHASE_ITEMS) begin
				roll = $urandom_range(99);
				if (roll < 55)      kind = WIN_TYPICAL;
				else if (roll < 67) kind = WIN_BORDER;
				else if (roll < 73) kind = WIN_ZERO_GAP;
				else if (roll < 83) kind = WIN_WILD;
				else if (roll < 93) kind = WIN_ABANDON;
				else                kind = WIN_STRAY;
				measure_window(kind);
			end
		end

		drain_results();
		$display("Sent %0d input transfers, checked %0d results (%0d failed windows),",
			items_sent, results, failed_windows);
		$display("across six clock settings, three stall patterns and a long output hold.");
		if (mismatches == 0 && awaited == 0) begin
			$display("baud_rate_meter_top: match");
		end else begin
			$display("baud_rate_meter_top: mismatch");
		end
		$finish;
	end

endmodule
